// File: rtl/core/htbp_pkg.sv
// shared types, constants and character classes for the hex text parser
// no dependencies; imported by every module under rtl/core
package htbp_pkg;

  // character position counter
  localparam int CHAR_IDX_W = 16;
  localparam logic [CHAR_IDX_W-1:0] MAX_CHARS = 16'hFFFF;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // character codes used by the decoder
  localparam logic [15:0] CH_COMMA = 16'h002C;
  localparam logic [15:0] CH_SEMI  = 16'h003B;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_DASH  = 16'h002D;
  localparam logic [15:0] CH_LO_X  = 16'h0078;
  localparam logic [15:0] CH_UP_X  = 16'h0058;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_LO_A  = 16'h0061;
  localparam logic [15:0] CH_LO_F  = 16'h0066;
  localparam logic [15:0] CH_UP_A  = 16'h0041;
  localparam logic [15:0] CH_UP_F  = 16'h0046;
  localparam logic [4:0]  ALPHA_BASE = 5'd10;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // final status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_ODD     = 2'd3
  } status_t;

  // input request
  typedef struct packed {
    logic [15:0] char_code;
    logic        end_of_text;
  } in_item_t;

  // result request
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [15:0] error_position;
    logic [15:0] error_char;
    logic        last_result;
  } out_item_t;

  // decoded character class
  typedef struct packed {
    logic       is_sep;
    logic       is_x;
    logic       is_zero;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  // queue write port
  typedef struct packed {
    logic [1:0] count;
    out_item_t  slot0;
    out_item_t  slot1;
  } fifo_push_t;

endpackage

// File: rtl/core/htbp_classify.sv
// character classifier: separators, prefix letters and hex digit value
// depends on htbp_pkg
module htbp_classify (
  input  logic [15:0]          char_code,
  output htbp_pkg::char_class_t cls
);
  import htbp_pkg::*;

  logic       space_hit;
  logic [4:0] digit_sum;

  // unicode whitespace set
  always_comb begin
    space_hit = (char_code == 16'h0020) ||
                (char_code >= 16'h0009 && char_code <= 16'h000D) ||
                (char_code == 16'h0085) || (char_code == 16'h00A0) ||
                (char_code == 16'h1680) ||
                (char_code >= 16'h2000 && char_code <= 16'h200A) ||
                (char_code == 16'h2028) || (char_code == 16'h2029) ||
                (char_code == 16'h202F) || (char_code == 16'h205F) ||
                (char_code == 16'h3000);
  end

  // hex digit value
  always_comb begin
    cls.is_hex = 1'b1;
    digit_sum  = '0;
    priority if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      digit_sum = {1'b0, char_code[3:0]};
    end else if (char_code >= CH_LO_A && char_code <= CH_LO_F) begin
      digit_sum = ALPHA_BASE + 5'(char_code[3:0] - 4'd1);
    end else if (char_code >= CH_UP_A && char_code <= CH_UP_F) begin
      digit_sum = ALPHA_BASE + 5'(char_code[3:0] - 4'd1);
    end else begin
      cls.is_hex = 1'b0;
    end
    cls.nibble  = digit_sum[3:0];
    cls.is_sep  = space_hit || (char_code == CH_COMMA) || (char_code == CH_SEMI) ||
                  (char_code == CH_COLON) || (char_code == CH_DASH);
    cls.is_x    = (char_code == CH_LO_X) || (char_code == CH_UP_X);
    cls.is_zero = (char_code == CH_ZERO);
  end

endmodule

// File: rtl/core/htbp_out_fifo.sv
// result queue: takes up to two results a cycle, gives one a cycle while out_stall is low
// depends on htbp_pkg
module htbp_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  htbp_pkg::fifo_push_t  push,
  output logic                  room2,
  output logic                  out_valid,
  input  logic                  out_stall,
  output htbp_pkg::out_item_t   out_item
);
  import htbp_pkg::*;

  out_item_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign room2     = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      mem_r[FIFO_PTR_W'(wr_ptr_r + FIFO_PTR_W'(1))] <= push.slot1;
    end
  end

endmodule

// File: rtl/core/hex_text_to_bytes_parser.sv
// top level of the hex text to byte parser: input register, parse state, result queue
// depends on htbp_pkg, htbp_classify and htbp_out_fifo
//
//  channel   ports                          direction  contents
//  input     in_valid in_stall in_item      in         one text character + end flag
//  result    out_valid out_stall out_item   out        data byte or final status
//
// one character is taken per cycle while in_stall is low; each passes an input
// register and is then parsed into a four-entry result queue.
// a character gives at most one data byte and the final one adds a status.
// in_stall rises only when the input register holds a character and the queue
// lacks room for two results. reset is synchronous and clears all parse state.
module hex_text_to_bytes_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  htbp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output htbp_pkg::out_item_t out_item
);
  import htbp_pkg::*;

  // input register
  logic        stage_v_r, stage_v_nxt;
  in_item_t    stage_r;

  // parse state
  logic [3:0]            high_nibble_r, high_nibble_nxt;
  logic                  have_high_r, have_high_nxt;
  logic                  zero_held_r, zero_held_nxt;
  logic                  any_digit_r, any_digit_nxt;
  logic [CHAR_IDX_W-1:0] char_index_r, char_index_nxt;
  logic                  error_seen_r, error_seen_nxt;
  logic [CHAR_IDX_W-1:0] error_index_r, error_index_nxt;
  logic [15:0]           error_code_r, error_code_nxt;

  char_class_t cls;
  fifo_push_t  push;
  logic        room2;
  logic        accept;
  logic        process;
  logic        byte_v;
  logic [7:0]  byte_val;
  logic        consumed;
  out_item_t   data_res;
  out_item_t   stat_res;

  htbp_classify u_classify (
    .char_code (stage_r.char_code),
    .cls       (cls)
  );

  htbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // handshake on the input register
  assign process  = stage_v_r && room2;
  assign in_stall = stage_v_r && !room2;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      stage_v_nxt = 1'b1;
    end else if (process) begin
      stage_v_nxt = 1'b0;
    end else begin
      stage_v_nxt = stage_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= in_item;
    end
  end

  // parse one character: held zero first, then the character itself
  always_comb begin
    high_nibble_nxt = high_nibble_r;
    have_high_nxt   = have_high_r;
    zero_held_nxt   = zero_held_r;
    any_digit_nxt   = any_digit_r;
    error_seen_nxt  = error_seen_r;
    error_index_nxt = error_index_r;
    error_code_nxt  = error_code_r;
    byte_v          = 1'b0;
    byte_val        = '0;
    consumed        = 1'b0;

    char_index_nxt = (char_index_r == MAX_CHARS) ? char_index_r
                                                 : char_index_r + CHAR_IDX_W'(1);

    if (!error_seen_r) begin
      // resolve a held zero
      if (zero_held_r) begin
        zero_held_nxt = 1'b0;
        if (cls.is_x) begin
          consumed = 1'b1;
        end else begin
          any_digit_nxt = 1'b1;
          if (have_high_nxt) begin
            byte_v          = 1'b1;
            byte_val        = {high_nibble_nxt, 4'h0};
            have_high_nxt   = 1'b0;
            high_nibble_nxt = '0;
          end else begin
            high_nibble_nxt = '0;
            have_high_nxt   = 1'b1;
          end
        end
      end
      // current character
      if (!consumed && !cls.is_sep) begin
        if (cls.is_zero && !stage_r.end_of_text) begin
          zero_held_nxt = 1'b1;
        end else if (!cls.is_hex) begin
          error_seen_nxt  = 1'b1;
          error_index_nxt = char_index_nxt;
          error_code_nxt  = stage_r.char_code;
        end else begin
          any_digit_nxt = 1'b1;
          if (have_high_nxt) begin
            byte_v          = 1'b1;
            byte_val        = {high_nibble_nxt, cls.nibble};
            have_high_nxt   = 1'b0;
            high_nibble_nxt = '0;
          end else begin
            high_nibble_nxt = cls.nibble;
            have_high_nxt   = 1'b1;
          end
        end
      end
    end
  end

  // result words
  always_comb begin
    data_res                = '0;
    data_res.kind           = KIND_DATA;
    data_res.data_byte      = byte_val;
    data_res.status         = STATUS_OK;

    stat_res                = '0;
    stat_res.kind           = KIND_STATUS;
    stat_res.last_result    = 1'b1;
    priority if (error_seen_nxt) begin
      stat_res.status         = STATUS_INVALID;
      stat_res.error_position = error_index_nxt[15:0];
      stat_res.error_char     = error_code_nxt;
    end else if (!any_digit_nxt) begin
      stat_res.status = STATUS_EMPTY;
    end else if (have_high_nxt) begin
      stat_res.status = STATUS_ODD;
    end else begin
      stat_res.status = STATUS_OK;
    end
  end

  // queue write
  always_comb begin
    push.slot0 = byte_v ? data_res : stat_res;
    push.slot1 = stat_res;
    if (!process) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'(byte_v) + 2'(stage_r.end_of_text);
    end
  end

  // state update; end of message returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_nibble_r <= '0;
      have_high_r   <= 1'b0;
      zero_held_r   <= 1'b0;
      any_digit_r   <= 1'b0;
      char_index_r  <= '0;
      error_seen_r  <= 1'b0;
      error_index_r <= '0;
      error_code_r  <= '0;
    end else if (process) begin
      if (stage_r.end_of_text) begin
        high_nibble_r <= '0;
        have_high_r   <= 1'b0;
        zero_held_r   <= 1'b0;
        any_digit_r   <= 1'b0;
        char_index_r  <= '0;
        error_seen_r  <= 1'b0;
        error_index_r <= '0;
        error_code_r  <= '0;
      end else begin
        high_nibble_r <= high_nibble_nxt;
        have_high_r   <= have_high_nxt;
        zero_held_r   <= zero_held_nxt;
        any_digit_r   <= any_digit_nxt;
        char_index_r  <= char_index_nxt;
        error_seen_r  <= error_seen_nxt;
        error_index_r <= error_index_nxt;
        error_code_r  <= error_code_nxt;
      end
    end
  end

endmodule

// File: verif/htbp_checker.sv
// checker for the hex text parser: watches both request channels, predicts each result
// from the accepted characters and compares field by field; depends on htbp_pkg
module htbp_checker
  import htbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 30;

  // parse state of the predictor
  logic [3:0]  hi_nib;
  logic        hi_pending;
  logic        zero_pending;
  logic        saw_digit;
  logic [15:0] position;
  logic        failed;
  logic [15:0] fail_pos;
  logic [15:0] fail_code;

  out_item_t expected_results[$];
  int        results_seen;

  initial begin
    mismatch_count = 0;
    pending_results = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic clear_parse_state();
    hi_nib = '0;
    hi_pending = 1'b0;
    zero_pending = 1'b0;
    saw_digit = 1'b0;
    position = '0;
    failed = 1'b0;
    fail_pos = '0;
    fail_code = '0;
  endtask

  // unicode whitespace plus the four separators
  function automatic logic is_separator(input logic [15:0] c);
    if (c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000D)) return 1'b1;
    if (c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) return 1'b1;
    if (c >= 16'h2000 && c <= 16'h200A) return 1'b1;
    if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F) return 1'b1;
    if (c == 16'h205F || c == 16'h3000) return 1'b1;
    return (c == CH_COMMA || c == CH_SEMI || c == CH_COLON || c == CH_DASH);
  endfunction

  // nibble value of a hex digit, -1 for anything else
  function automatic int hex_value(input logic [15:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + int'(ALPHA_BASE);
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + int'(ALPHA_BASE);
    return -1;
  endfunction

  // merge a nibble, a byte comes out on every second one
  task automatic take_digit(input logic [3:0] nib);
    out_item_t r;
    saw_digit = 1'b1;
    if (hi_pending) begin
      r = '0;
      r.kind = KIND_DATA;
      r.data_byte = {hi_nib, nib};
      r.status = STATUS_OK;
      r.last_result = 1'b0;
      expected_results.push_back(r);
      hi_pending = 1'b0;
      hi_nib = '0;
    end else begin
      hi_nib = nib;
      hi_pending = 1'b1;
    end
  endtask

  // one accepted character request
  task automatic parse_char(input in_item_t req);
    logic [15:0] c;
    logic        eot;
    logic        prefix_taken;
    int          nib;
    out_item_t   r;
    c = req.char_code;
    eot = req.end_of_text;
    prefix_taken = 1'b0;
    if (position != MAX_CHARS) position++;
    if (!failed) begin
      // a held zero either starts a prefix or is a digit
      if (zero_pending) begin
        zero_pending = 1'b0;
        if (c == CH_LO_X || c == CH_UP_X) prefix_taken = 1'b1;
        else take_digit(4'h0);
      end
      if (!prefix_taken && !is_separator(c)) begin
        if (c == CH_ZERO && !eot) begin
          zero_pending = 1'b1;
        end else begin
          nib = hex_value(c);
          if (nib < 0) begin
            failed = 1'b1;
            fail_pos = position;
            fail_code = c;
          end else begin
            take_digit(nib[3:0]);
          end
        end
      end
    end
    // final status, then back to idle state
    if (eot) begin
      r = '0;
      r.kind = KIND_STATUS;
      r.last_result = 1'b1;
      if (failed) begin
        r.status = STATUS_INVALID;
        r.error_position = fail_pos;
        r.error_char = fail_code;
      end else if (!saw_digit) begin
        r.status = STATUS_EMPTY;
      end else if (hi_pending) begin
        r.status = STATUS_ODD;
      end else begin
        r.status = STATUS_OK;
      end
      expected_results.push_back(r);
      clear_parse_state();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0h", got));
      return;
    end
    want = expected_results.pop_front();
    check_field("kind", 16'(got.kind), 16'(want.kind));
    check_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
    check_field("status", 16'(got.status), 16'(want.status));
    check_field("error_position", got.error_position, want.error_position);
    check_field("error_char", got.error_char, want.error_char);
    check_field("last_result", 16'(got.last_result), 16'(want.last_result));
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse_state();
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) parse_char(in_item);
      if (out_valid && !out_stall) check_result(out_item);
    end
    pending_results <= expected_results.size();
  end

endmodule

// File: verif/testbench.sv
// top of the hex text parser testbench: clock, reset, character stimulus and verdict
// depends on htbp_pkg, hex_text_to_bytes_parser and htbp_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htbp_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_CHARS  = 650;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chars_sent     = 0;
  int quiet_cycles   = 0;
  int mismatches;
  int pending;

  hex_text_to_bytes_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  htbp_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .mismatch_count  (mismatches),
    .pending_results (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  initial out_stall <= 1'b0;
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("hex_text_to_bytes_parser verification failed");
      $finish;
    end
  end

  // one character request, with random idle cycles ahead of it
  task automatic send_char(input logic [15:0] code, input logic last);
    in_item_t req;
    req.char_code = code;
    req.end_of_text = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]}, i == s.len() - 1);
  endtask

  function automatic logic [15:0] random_hex_digit();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return {8'h00, digits[$urandom_range(21)]};
  endfunction

  // skipped characters: separators and unicode whitespace
  function automatic logic [15:0] random_separator();
    case ($urandom_range(11))
      0:       return CH_COMMA;
      1:       return CH_SEMI;
      2:       return CH_COLON;
      3:       return CH_DASH;
      4:       return 16'h0020;
      5:       return 16'($urandom_range(16'h000D, 16'h0009));
      6:       return ($urandom_range(1) == 1) ? 16'h0085 : 16'h00A0;
      7:       return 16'h1680;
      8:       return 16'($urandom_range(16'h200A, 16'h2000));
      9:       return ($urandom_range(1) == 1) ? 16'h2028 : 16'h2029;
      10:      return ($urandom_range(1) == 1) ? 16'h202F : 16'h205F;
      default: return 16'h3000;
    endcase
  endfunction

  // mostly well-formed message with random content, some odd or with noise
  task automatic send_random_message();
    logic [15:0] text[$];
    int          pairs;
    int          style;
    pairs = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6);
    style = $urandom_range(99);
    for (int i = 0; i < pairs * 2; i++) begin
      if ($urandom_range(9) == 0) begin
        text.push_back(CH_ZERO);
        text.push_back(($urandom_range(1) == 1) ? CH_LO_X : CH_UP_X);
      end
      if ($urandom_range(4) == 0) text.push_back(random_separator());
      text.push_back(random_hex_digit());
    end
    if (style < 12) text.push_back(random_hex_digit());
    else if (style < 30) text.insert($urandom_range(text.size()), 16'($urandom_range(65535)));
    if (text.size() == 0 || $urandom_range(3) == 0) text.push_back(random_separator());
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int goal;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = chars_sent + PHASE_CHARS;
    while (chars_sent < goal) send_random_message();
  endtask

  initial begin
    in_valid <= 1'b0;
    in_item <= '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero on the final item, both prefixes, empty, separators, errors
    send_text("0");
    send_text("0xAb");
    send_text("00");
    send_text(" ");
    send_text("0X");
    send_text("1,0;9:F-");
    send_text("10Z");
    send_char(16'hFFFF, 1'b1);
    send_char(16'h0000, 1'b0);
    send_char(16'h3000, 1'b1);

    run_phase(31, 52);
    run_phase(52, 31);
    run_phase(0, 0);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("hex_text_to_bytes_parser verification clean");
    end else begin
      $display("hex_text_to_bytes_parser verification failed");
    end
    $finish;
  end

endmodule
